// ===== design/ofm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_pkg
// Shared widths, codes and types of the occupancy frontier marker.
// ----------------------------------------------------------------------------
package ofm_pkg;

  // Field widths
  localparam int OCC_W      = 8;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int GW_W       = 11;
  localparam int GH_W       = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int GRID_DIM_RST  = 1024;
  localparam int MIN_DIM       = 3;

  // Cell codes
  localparam logic [OCC_W-1:0] CELL_UNKNOWN = 8'hFF;
  localparam logic [OCC_W-1:0] CELL_FREE    = 8'h00;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;

  typedef logic signed [OCC_W-1:0] occ_t;

  typedef struct packed {
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    occ_t             cell_value;
    logic             is_frontier;
    logic             last;
  } result_t;

endpackage

// ===== design/ofm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_in_if
// Input channel: one occupancy cell per item.
// ----------------------------------------------------------------------------
interface ofm_in_if;
  logic          valid;
  logic          ready;
  ofm_pkg::occ_t occupancy;

  modport source (output valid, output occupancy, input ready);
  modport sink   (input valid, input occupancy, output ready);
endinterface

// ===== design/ofm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_out_if
// Result channel: one cell verdict per item.
// ----------------------------------------------------------------------------
interface ofm_out_if;
  logic                        valid;
  logic                        ready;
  logic [ofm_pkg::ROW_W-1:0]   cell_row;
  logic [ofm_pkg::COL_W-1:0]   cell_col;
  ofm_pkg::occ_t               cell_value;
  logic                        is_frontier;
  logic                        last;

  modport source (output valid, output cell_row, output cell_col, output cell_value,
                  output is_frontier, output last, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input cell_value,
                  input is_frontier, input last, output ready);
endinterface

// ===== design/ofm_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ofm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ofm_pkg::CFG_IDX_W-1:0]    index;
  logic [ofm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ofm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ofm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/occupancy_frontier_marker_unit.sv =====
`timescale 1ns / 1ps
// Verdicts: each is registered first in stage one, with its window's closing cell, and then
//   in the result group, from which the output offers it.
// Throughput: one cell per cycle while the output keeps up and no configuration write
//   is offered; a cell with more than one verdict holds the input until they are taken (row
//   ends and last-row cells two, the frame's final cell four), and output stalls hold it further.
// Reset: counters, window and pipeline clear; width min(MAX_WIDTH, 1024), height 1024; no store clear.
// ----------------------------------------------------------------------------
// occupancy_frontier_marker_unit
// 3x3 frontier detection over a raster stream of occupancy cells, with two map
// rows kept packed in one line store word per column.
// ----------------------------------------------------------------------------
module occupancy_frontier_marker_unit #(
  parameter int MAX_WIDTH = ofm_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  ofm_in_if.sink          in_ch,
  ofm_out_if.source       out_ch,
  ofm_cfg_if.sink         cfg_ch
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WRST = (MAX_WIDTH < ofm_pkg::GRID_DIM_RST) ? MAX_WIDTH
                                                            : ofm_pkg::GRID_DIM_RST;
  localparam logic [CW-1:0]               WLAST_RST = CW'(WRST - 1);
  localparam logic [ofm_pkg::ROW_W-1:0]   HLAST_RST = ofm_pkg::ROW_W'(ofm_pkg::GRID_DIM_RST - 1);
  localparam int LW = 2 * ofm_pkg::OCC_W;

  typedef struct packed {
    logic [ofm_pkg::ROW_W-1:0] row;
    logic [CW-1:0]             col;
    ofm_pkg::occ_t             value;
    logic                      r_ge1;
    logic                      c_ge1;
    logic                      r_last;
    logic                      c_last;
    logic [2:0]                rint;
    logic [2:0]                cint;
  } stage_t;

  // Configuration and position state
  logic [CW-1:0]             wlast_r, wlast_nxt;
  logic [ofm_pkg::ROW_W-1:0] hlast_r, hlast_nxt;
  logic [ofm_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]             col_r, col_nxt;

  // Pipeline
  logic                      s1_vld_r, s1_vld_nxt;
  stage_t                    s1_r, s1_nxt;
  logic [ofm_pkg::OCC_W-1:0] win_r [3][3];
  logic [ofm_pkg::OCC_W-1:0] win_nxt [3][3];
  logic [ofm_pkg::OCC_W-1:0] ws [3][3];
  logic [3:0]                grp_vld_r, grp_vld_nxt;
  ofm_pkg::result_t          grp_res_r [4];
  ofm_pkg::result_t          res [4];
  logic [3:0]                res_mask;
  logic [2:0][2:0]           unk;
  ofm_pkg::result_t          out_sel;

  // Handshakes
  logic cfg_acc, restart, in_acc, out_acc, grp_free, s1_adv;
  logic col_last, row_last;

  // Line store
  logic [LW-1:0] ram_rdata, ram_wdata;
  logic          ram_we, ram_re;
  logic [CW-1:0] ram_waddr, ram_raddr;

  // Handshake control
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign restart      = cfg_acc && (cfg_ch.index == ofm_pkg::REG_GRID_WIDTH ||
                                    cfg_ch.index == ofm_pkg::REG_GRID_HEIGHT);
  assign grp_free     = (grp_vld_r == 4'd0) || ($onehot(grp_vld_r) && out_ch.ready);
  assign s1_adv       = s1_vld_r && grp_free;
  assign in_ch.ready  = (!s1_vld_r || s1_adv) && !cfg_ch.valid;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;

  assign col_last = (col_r == wlast_r);
  assign row_last = (row_r == hlast_r);

  // Line store: word per column holds {row r-1, row r-2}
  assign ram_re    = in_acc;
  assign ram_raddr = col_r;
  assign ram_we    = s1_adv;
  assign ram_waddr = s1_r.col;
  assign ram_wdata = {s1_r.value, ram_rdata[LW-1 -: ofm_pkg::OCC_W]};

  ofm_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Register writes: clamp width and height, keep last index
  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_acc && cfg_ch.index == ofm_pkg::REG_GRID_WIDTH) begin
      if (cfg_ch.data[ofm_pkg::GW_W-1:0] < ofm_pkg::GW_W'(ofm_pkg::MIN_DIM)) begin
        wlast_nxt = CW'(ofm_pkg::MIN_DIM - 1);
      end else if (32'(cfg_ch.data[ofm_pkg::GW_W-1:0]) > 32'(MAX_WIDTH)) begin
        wlast_nxt = CW'(MAX_WIDTH - 1);
      end else begin
        wlast_nxt = CW'(cfg_ch.data[ofm_pkg::GW_W-1:0] - ofm_pkg::GW_W'(1));
      end
    end
    if (cfg_acc && cfg_ch.index == ofm_pkg::REG_GRID_HEIGHT) begin
      if (cfg_ch.data[ofm_pkg::GH_W-1:0] < ofm_pkg::GH_W'(ofm_pkg::MIN_DIM)) begin
        hlast_nxt = ofm_pkg::ROW_W'(ofm_pkg::MIN_DIM - 1);
      end else begin
        hlast_nxt = cfg_ch.data[ofm_pkg::GH_W-1:0] - ofm_pkg::GH_W'(1);
      end
    end
  end

  // Advance the raster position and load stage one
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    s1_vld_nxt = s1_vld_r;
    s1_nxt     = s1_r;
    if (restart) begin
      row_nxt    = '0;
      col_nxt    = '0;
      s1_vld_nxt = 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld_nxt = 1'b0;
      end
      if (in_acc) begin
        s1_vld_nxt     = 1'b1;
        s1_nxt.row     = row_r;
        s1_nxt.col     = col_r;
        s1_nxt.value   = in_ch.occupancy;
        s1_nxt.r_ge1   = (row_r != '0);
        s1_nxt.c_ge1   = (col_r != '0);
        s1_nxt.r_last  = row_last;
        s1_nxt.c_last  = col_last;
        s1_nxt.rint[0] = (row_r >= ofm_pkg::ROW_W'(3));
        s1_nxt.rint[1] = (row_r >= ofm_pkg::ROW_W'(2));
        s1_nxt.rint[2] = (row_r != '0) && !row_last;
        s1_nxt.cint[0] = (col_r >= CW'(3));
        s1_nxt.cint[1] = (col_r >= CW'(2));
        s1_nxt.cint[2] = (col_r != '0) && !col_last;
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_last ? '0 : row_r + ofm_pkg::ROW_W'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  // Shift the window left and bring in the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ws[i][0] = win_r[i][1];
      ws[i][1] = win_r[i][2];
    end
    ws[0][2] = ram_rdata[ofm_pkg::OCC_W-1:0];
    ws[1][2] = ram_rdata[LW-1 -: ofm_pkg::OCC_W];
    ws[2][2] = s1_r.value;
  end

  // Mark unknown cells that lie in the interior
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        unk[i][j] = (ws[i][j] == ofm_pkg::CELL_UNKNOWN) && s1_r.rint[i] && s1_r.cint[j];
      end
    end
  end

  // Judge the up to four cells whose windows close with this item
  always_comb begin
    logic [1:0] ci, cj;
    logic       fr;
    for (int k = 0; k < 4; k++) begin
      ci = (k >= 2) ? 2'd2 : 2'd1;
      cj = (k == 1 || k == 3) ? 2'd2 : 2'd1;
      fr = 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (!(i == int'(ci) && j == int'(cj)) && i >= int'(ci) - 1 && j >= int'(cj) - 1
              && unk[i][j]) begin
            fr = 1'b1;
          end
        end
      end
      res[k].cell_row    = (k >= 2) ? s1_r.row : s1_r.row - ofm_pkg::ROW_W'(1);
      res[k].cell_col    = (k == 1 || k == 3) ? ofm_pkg::COL_W'(s1_r.col)
                                              : ofm_pkg::COL_W'(s1_r.col - CW'(1));
      res[k].cell_value  = ws[ci][cj];
      res[k].is_frontier = (ws[ci][cj] == ofm_pkg::CELL_FREE) && fr;
      res[k].last        = (k == 3);
    end
    res_mask[0] = s1_r.r_ge1 && s1_r.c_ge1;
    res_mask[1] = s1_r.r_ge1 && s1_r.c_last;
    res_mask[2] = s1_r.r_ge1 && s1_r.r_last && s1_r.c_ge1;
    res_mask[3] = s1_r.r_ge1 && s1_r.r_last && s1_r.c_last;
  end

  // Window and result group next values
  always_comb begin
    win_nxt     = win_r;
    grp_vld_nxt = grp_vld_r;
    if (restart) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_nxt[i][j] = '0;
        end
      end
      grp_vld_nxt = '0;
    end else if (s1_adv) begin
      win_nxt     = ws;
      grp_vld_nxt = res_mask;
    end else if (out_acc) begin
      // drop the verdict just taken
      grp_vld_nxt = grp_vld_r & (grp_vld_r - 4'd1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r   <= WLAST_RST;
      hlast_r   <= HLAST_RST;
      row_r     <= '0;
      col_r     <= '0;
      s1_vld_r  <= 1'b0;
      grp_vld_r <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      wlast_r   <= wlast_nxt;
      hlast_r   <= hlast_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      s1_vld_r  <= s1_vld_nxt;
      grp_vld_r <= grp_vld_nxt;
      win_r     <= win_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_adv) begin
      grp_res_r <= res;
    end
  end

  // Offer the verdicts of a group in raster order
  always_comb begin
    priority if (grp_vld_r[0]) begin
      out_sel = grp_res_r[0];
    end else if (grp_vld_r[1]) begin
      out_sel = grp_res_r[1];
    end else if (grp_vld_r[2]) begin
      out_sel = grp_res_r[2];
    end else begin
      out_sel = grp_res_r[3];
    end
  end

  assign out_ch.valid       = |grp_vld_r;
  assign out_ch.cell_row    = out_sel.cell_row;
  assign out_ch.cell_col    = out_sel.cell_col;
  assign out_ch.cell_value  = out_sel.cell_value;
  assign out_ch.is_frontier = out_sel.is_frontier;
  assign out_ch.last        = out_sel.last;

`ifndef NO_ASSERTIONS
  // A new group only replaces one that is empty or losing its final verdict
  a_group_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> ($countones(grp_vld_r) <= 1))
    else $error("result group overwritten while verdicts remain");

  // Read-modify-write of the line store never meets the same column
  a_line_store_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line store read and write collide on one column");

  // A group with verdicts left keeps offering after one is taken
  a_group_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && $countones(grp_vld_r) >= 2 && !cfg_acc) |=> out_ch.valid)
    else $error("verdicts lost while draining a group");

  // The column counter wraps after the row's last cell
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_last) |=> (col_r == '0))
    else $error("column counter failed to wrap at row end");
`endif

endmodule
